### rtl/core/e2c_pkg.sv
// Shared types and constants for the equirect-to-cube-face address pipeline.
`timescale 1ns / 1ps

package e2c_pkg;

    // Signed direction component; covers face sizes up to 8191.
    localparam int CMP_W   = 14;
    // x^2 + z^2
    localparam int SQ_W    = 26;
    // Integer fraction bits added before the square root.
    localparam int SQ_FRAC = 32;
    // Root of (x^2 + z^2) << 32
    localparam int ROOT_W  = (SQ_W + SQ_FRAC) / 2;
    localparam int REM_W   = ROOT_W + 3;
    // CORDIC datapath and angle accumulator (1.0 = pi at 18 fraction bits)
    localparam int CORD_W  = 33;
    localparam int ANG_W   = 21;
    localparam int ANG_FRAC = 18;
    localparam int TAB_LEN = 24;
    localparam logic signed [ANG_W-1:0] ANG_ONE = 21'sd262144;

    localparam int FACE_W = 13;
    localparam int DIM_W  = 14;

    typedef enum logic [1:0] {
        REG_FACE_SIZE  = 2'd0,
        REG_SRC_WIDTH  = 2'd1,
        REG_SRC_HEIGHT = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [2:0]  face_slot;
        logic [11:0] column;
        logic [11:0] row;
    } pix_t;

    typedef struct packed {
        logic [12:0] src_x;
        logic [12:0] src_y;
        logic [25:0] src_address;
        logic        coord_invalid;
    } src_t;

    typedef struct packed {
        logic                    invalid;
        logic signed [CMP_W-1:0] x;
        logic signed [CMP_W-1:0] y;
        logic signed [CMP_W-1:0] z;
    } dir_t;

endpackage

### rtl/core/e2c_dir.sv
// Direction vector per face slot and the squared horizontal radius (two stages).
`timescale 1ns / 1ps

module e2c_dir
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  pix_t              pix,
    input  logic [FACE_W-1:0] f,
    output logic              out_valid,
    output dir_t              dir,
    output logic [SQ_W-1:0]   n
);

    localparam logic [2:0] SLOT_POS_Z_A = 3'd0;
    localparam logic [2:0] SLOT_NEG_Z_A = 3'd1;
    localparam logic [2:0] SLOT_NEG_Y   = 3'd2;
    localparam logic [2:0] SLOT_POS_Y   = 3'd3;
    localparam logic [2:0] SLOT_POS_X   = 3'd4;
    localparam logic [2:0] SLOT_NEG_X   = 3'd5;
    localparam logic [2:0] SLOT_ALIAS_4 = 3'd6;
    localparam logic [2:0] SLOT_ALIAS_5 = 3'd7;

    logic        v1_reg, v1_next;
    dir_t        d1_reg, d1_next;
    logic        v2_reg;
    dir_t        d2_reg;
    logic [SQ_W-1:0] n2_reg, n2_next;

    logic signed [14:0] f_s, h_s, c_s, r_s, x_s, y_s, z_s;
    logic signed [2*CMP_W-1:0] xx, zz;
    logic signed [2*CMP_W:0]   sum;

    always_comb
    begin
        f_s = $signed({2'b00, f});
        h_s = $signed({3'b000, f[FACE_W-1:1]});
        c_s = $signed({3'b000, pix.column});
        r_s = $signed({3'b000, pix.row});
        case (pix.face_slot)
            SLOT_POS_Z_A:
            begin
                x_s = (f_s - r_s) - h_s; y_s = c_s - h_s; z_s = h_s;
            end
            SLOT_NEG_Z_A:
            begin
                x_s = h_s - (f_s - r_s); y_s = c_s - h_s; z_s = -h_s;
            end
            SLOT_NEG_Y:
            begin
                x_s = c_s - h_s; y_s = -h_s; z_s = r_s - h_s;
            end
            SLOT_POS_Y:
            begin
                x_s = h_s - c_s; y_s = h_s; z_s = h_s - r_s;
            end
            SLOT_POS_X, SLOT_ALIAS_4:
            begin
                x_s = h_s; y_s = c_s - h_s; z_s = r_s - h_s;
            end
            SLOT_NEG_X, SLOT_ALIAS_5:
            begin
                x_s = -h_s; y_s = c_s - h_s; z_s = h_s - r_s;
            end
            default:
            begin
                x_s = h_s; y_s = c_s - h_s; z_s = r_s - h_s;
            end
        endcase
        v1_next         = in_valid;
        d1_next.invalid = ({1'b0, pix.column} >= f) || ({1'b0, pix.row} >= f);
        d1_next.x       = CMP_W'(x_s);
        d1_next.y       = CMP_W'(y_s);
        d1_next.z       = CMP_W'(z_s);

        xx      = $signed(d1_reg.x) * $signed(d1_reg.x);
        zz      = $signed(d1_reg.z) * $signed(d1_reg.z);
        sum     = (2*CMP_W+1)'(xx) + (2*CMP_W+1)'(zz);
        n2_next = sum[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg <= d1_next;
            d2_reg <= d1_reg;
            n2_reg <= n2_next;
        end
    end

    assign out_valid = v2_reg;
    assign dir       = d2_reg;
    assign n         = n2_reg;

endmodule

### rtl/core/e2c_sqrt.sv
// Pipelined integer square root of (n << 32), one root bit per stage.
`timescale 1ns / 1ps

module e2c_sqrt
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  dir_t              dir_in,
    input  logic [SQ_W-1:0]   n,
    output logic              out_valid,
    output dir_t              dir_out,
    output logic [ROOT_W-1:0] root
);

    typedef struct packed {
        dir_t              d;
        logic [SQ_W-1:0]   n;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    logic [ROOT_W-1:0] vld_reg;
    sq_stage_t         st_reg  [ROOT_W];
    sq_stage_t         st_next [ROOT_W];

    always_comb
    begin
        sq_stage_t                cur;
        logic [2*ROOT_W-1:0]      big;
        logic [1:0]               pair;
        logic [REM_W-1:0]         rem_sh;
        logic [REM_W-1:0]         trial;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                cur.d    = dir_in;
                cur.n    = n;
                cur.rem  = '0;
                cur.root = '0;
            end
            else
            begin
                cur = st_reg[i-1];
            end
            big    = {cur.n, {SQ_FRAC{1'b0}}};
            pair   = big[2*(ROOT_W-1-i) +: 2];
            rem_sh = {cur.rem[REM_W-3:0], pair};
            trial  = REM_W'({cur.root, 2'b01});
            st_next[i] = cur;
            if (rem_sh >= trial)
            begin
                st_next[i].rem  = rem_sh - trial;
                st_next[i].root = {cur.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rem  = rem_sh;
                st_next[i].root = {cur.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < ROOT_W; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign dir_out   = st_reg[ROOT_W-1].d;
    assign root      = st_reg[ROOT_W-1].root;

endmodule

### rtl/core/e2c_cordic.sv
// Two-lane pipelined vectoring CORDIC: azimuth and polar angle as fractions of pi.
`timescale 1ns / 1ps

module e2c_cordic
    import e2c_pkg::*;
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  dir_t                     dir,
    input  logic [ROOT_W-1:0]        root,
    output logic                     out_valid,
    output logic                     invalid,
    output logic signed [ANG_W-1:0]  theta,
    output logic signed [ANG_W-1:0]  phi
);

    localparam int NST = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    typedef struct packed {
        logic                     zero;
        logic signed [CORD_W-1:0] px;
        logic signed [CORD_W-1:0] py;
        logic signed [ANG_W-1:0]  acc;
    } lane_t;

    typedef struct packed {
        logic  invalid;
        lane_t th;
        lane_t ph;
    } cord_stage_t;

    // atan(2^-i)/pi, rounded, 18 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        case (i)
            0:  return 21'sd65536;
            1:  return 21'sd38688;
            2:  return 21'sd20442;
            3:  return 21'sd10377;
            4:  return 21'sd5208;
            5:  return 21'sd2607;
            6:  return 21'sd1304;
            7:  return 21'sd652;
            8:  return 21'sd326;
            9:  return 21'sd163;
            10: return 21'sd81;
            11: return 21'sd41;
            12: return 21'sd20;
            13: return 21'sd10;
            14: return 21'sd5;
            15: return 21'sd3;
            16: return 21'sd1;
            17: return 21'sd1;
            default: return 21'sd0;
        endcase
    endfunction

    // Angle of point (b, a); left half plane folded by a half turn.
    function automatic lane_t prep(input logic signed [CORD_W-1:0] a,
                                   input logic signed [CORD_W-1:0] b);
        lane_t o;
        o.zero = (a == '0) && (b == '0);
        o.px   = b;
        o.py   = a;
        o.acc  = '0;
        if (b < 0)
        begin
            o.acc = (a >= 0) ? ANG_ONE : -ANG_ONE;
            o.px  = -b;
            o.py  = -a;
        end
        return o;
    endfunction

    function automatic lane_t rot(input lane_t l, input int i);
        lane_t o;
        logic signed [CORD_W-1:0] dx, dy;
        o  = l;
        dx = l.px >>> i;
        dy = l.py >>> i;
        if (l.py >= 0)
        begin
            o.px  = l.px + dy;
            o.py  = l.py - dx;
            o.acc = l.acc + atan_step(i);
        end
        else
        begin
            o.px  = l.px - dy;
            o.py  = l.py + dx;
            o.acc = l.acc - atan_step(i);
        end
        return o;
    endfunction

    logic [NST:0] vld_reg;
    cord_stage_t  st_reg  [NST+1];
    cord_stage_t  st_next [NST+1];

    always_comb
    begin
        logic signed [CORD_W-1:0] xa, za, ya, ra;
        xa = CORD_W'(dir.x) <<< 16;
        za = CORD_W'(dir.z) <<< 16;
        ya = CORD_W'(dir.y) <<< 16;
        ra = $signed(CORD_W'(root));
        st_next[0].invalid = dir.invalid;
        st_next[0].th      = prep(xa, za);
        st_next[0].ph      = prep(ra, ya);
        for (int k = 1; k <= NST; k++)
        begin
            st_next[k].invalid = st_reg[k-1].invalid;
            st_next[k].th      = rot(st_reg[k-1].th, k - 1);
            st_next[k].ph      = rot(st_reg[k-1].ph, k - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NST; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = vld_reg[NST];
    assign invalid   = st_reg[NST].invalid;
    assign theta     = st_reg[NST].th.zero ? '0 : st_reg[NST].th.acc;
    assign phi       = st_reg[NST].ph.zero ? '0 : st_reg[NST].ph.acc;

endmodule

### rtl/core/e2c_scale.sv
// Angle to pixel scaling, edge clamp and linear address (three stages).
`timescale 1ns / 1ps

module e2c_scale
    import e2c_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic                    invalid,
    input  logic signed [ANG_W-1:0] theta,
    input  logic signed [ANG_W-1:0] phi,
    input  logic [DIM_W-1:0]        w,
    input  logic [DIM_W-1:0]        hgt,
    output logic                    out_valid,
    output src_t                    res
);

    localparam logic [ANG_W-2:0] U_MAX = (ANG_W-1)'(2 * 262144);
    localparam logic [ANG_FRAC:0] V_MAX = (ANG_FRAC+1)'(262144);

    logic             va_reg, vb_reg, vc_reg;
    logic             inv_a_reg, inv_b_reg;
    logic [DIM_W:0]   tx_a_reg, tx_a_next, ty_a_reg, ty_a_next;
    logic [DIM_W-1:0] px_b_reg, px_b_next, py_b_reg, py_b_next;
    src_t             res_reg, res_next;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W:0] t,
                                                   input logic [DIM_W-1:0] dim);
        if (dim == '0)
            return '0;
        else if (t >= {1'b0, dim})
            return dim - 1'b1;
        else
            return t[DIM_W-1:0];
    endfunction

    always_comb
    begin
        logic signed [ANG_W:0]          s_sum;
        logic [ANG_W-2:0]               s_u;
        logic [ANG_FRAC:0]              p_u;
        logic [ANG_W-1+DIM_W-1:0]       prod_x;
        logic [ANG_FRAC+DIM_W:0]        prod_y;
        logic [2*DIM_W-1:0]             row_off;

        s_sum = (ANG_W+1)'(ANG_ONE) + (ANG_W+1)'(theta);
        if (s_sum < 0)
            s_u = '0;
        else if (s_sum > $signed({2'b00, U_MAX}))
            s_u = U_MAX;
        else
            s_u = s_sum[ANG_W-2:0];
        if (phi < 0)
            p_u = '0;
        else if (phi > $signed({2'b00, V_MAX}))
            p_u = V_MAX;
        else
            p_u = phi[ANG_FRAC:0];
        prod_x    = s_u * w;
        prod_y    = p_u * hgt;
        tx_a_next = (DIM_W+1)'(prod_x >> (ANG_FRAC + 1));
        ty_a_next = (DIM_W+1)'(prod_y >> ANG_FRAC);

        px_b_next = clamp_dim(tx_a_reg, w);
        py_b_next = clamp_dim(ty_a_reg, hgt);

        row_off = py_b_reg * w;
        res_next.coord_invalid = inv_b_reg;
        if (inv_b_reg)
        begin
            res_next.src_x       = '0;
            res_next.src_y       = '0;
            res_next.src_address = '0;
        end
        else
        begin
            res_next.src_x       = px_b_reg[12:0];
            res_next.src_y       = py_b_reg[12:0];
            res_next.src_address = 26'(row_off + (2*DIM_W)'(px_b_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_a_reg <= invalid;
            tx_a_reg  <= tx_a_next;
            ty_a_reg  <= ty_a_next;
            inv_b_reg <= inv_a_reg;
            px_b_reg  <= px_b_next;
            py_b_reg  <= py_b_next;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vc_reg;
    assign res       = res_reg;

endmodule

### rtl/core/equirect_to_cube_face_address.sv
// Top level: cube-face pixel to equirectangular source pixel address pipeline.
//
//  channel  dir  handshake               word
//  pix      in   pix_valid / pix_stall   pix_t  (face_slot, column, row)
//  src      out  src_valid / src_stall   src_t  (src_x, src_y, src_address, coord_invalid)
//  cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word accepted per clock while the output word is not stalled; words pass the
// direction stages, the 29-step root pipeline, the CORDIC stages and the scale stages.
// The whole pipeline holds while the output word is stalled; nothing is dropped.
// Reset clears valid bits and loads face_size 2048, src_width 4096, src_height 2048.
// cfg_ready is always high; write only while no word is in flight.
`timescale 1ns / 1ps

module equirect_to_cube_face_address
    import e2c_pkg::*;
#(
    parameter int MAX_SRC_DIM   = 8192,
    parameter int MAX_FACE_DIM  = 4096,
    parameter int CORDIC_STAGES = 18
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  pix_t             pix,
    output logic             src_valid,
    input  logic             src_stall,
    output src_t             src,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic [FACE_W-1:0] face_size_reg;
    logic [DIM_W-1:0]  src_width_reg;
    logic [DIM_W-1:0]  src_height_reg;

    logic [FACE_W-1:0] f;
    logic [DIM_W-1:0]  w, hgt;
    logic              adv;

    logic              d_valid, s_valid, c_valid, c_invalid;
    dir_t              d_dir, s_dir;
    logic [SQ_W-1:0]   d_n;
    logic [ROOT_W-1:0] s_root;
    logic signed [ANG_W-1:0] c_theta, c_phi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg  <= FACE_W'(2048);
            src_width_reg  <= DIM_W'(4096);
            src_height_reg <= DIM_W'(2048);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FACE_SIZE:  face_size_reg  <= cfg_data[FACE_W-1:0];
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign f   = ({1'b0, face_size_reg} > 14'(MAX_FACE_DIM)) ?
                 FACE_W'(MAX_FACE_DIM) : face_size_reg;
    assign w   = ({1'b0, src_width_reg} > 15'(MAX_SRC_DIM)) ?
                 DIM_W'(MAX_SRC_DIM) : src_width_reg;
    assign hgt = ({1'b0, src_height_reg} > 15'(MAX_SRC_DIM)) ?
                 DIM_W'(MAX_SRC_DIM) : src_height_reg;

    // single pipeline enable: move unless the output word is held
    assign adv       = !(src_valid && src_stall);
    assign pix_stall = !adv;

    e2c_dir u_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pix_valid),
        .pix       (pix),
        .f         (f),
        .out_valid (d_valid),
        .dir       (d_dir),
        .n         (d_n)
    );

    e2c_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid),
        .dir_in    (d_dir),
        .n         (d_n),
        .out_valid (s_valid),
        .dir_out   (s_dir),
        .root      (s_root)
    );

    e2c_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .dir       (s_dir),
        .root      (s_root),
        .out_valid (c_valid),
        .invalid   (c_invalid),
        .theta     (c_theta),
        .phi       (c_phi)
    );

    e2c_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid),
        .invalid   (c_invalid),
        .theta     (c_theta),
        .phi       (c_phi),
        .w         (w),
        .hgt       (hgt),
        .out_valid (src_valid),
        .res       (src)
    );

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src.coord_invalid |->
            src.src_x == '0 && src.src_y == '0 && src.src_address == '0)
        else $error("invalid coordinate word carries a nonzero address");

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src.coord_invalid |->
            src.src_x == '0 || {1'b0, src.src_x} < w)
        else $error("src_x beyond source width");

    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src.coord_invalid |->
            src.src_y == '0 || {1'b0, src.src_y} < hgt)
        else $error("src_y beyond source height");

endmodule

### test/equirect_to_cube_face_address_test.sv
// Testbench for the equirect-to-cube-face address pipeline: predicts every word and checks it.
`timescale 1ns / 1ps

module equirect_to_cube_face_address_test;
    import e2c_pkg::*;

    localparam int  LATENCY    = 35 + 18;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  HOLD_LEN   = 400;
    localparam longint ANGLE_PI = 262144;
    localparam longint ATAN_LUT [24] = '{
        65536, 38688, 20442, 10377, 5208, 2607, 1304, 652,
        326, 163, 81, 41, 20, 10, 5, 3,
        1, 1, 0, 0, 0, 0, 0, 0
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             pix_valid = 1'b0;
    logic             pix_stall;
    pix_t             pix = '0;
    logic             src_valid;
    logic             src_stall = 1'b0;
    src_t             src;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    // model copy of the registers
    logic [12:0] face_size_q = 13'd2048;
    logic [13:0] src_width_q = 14'd4096;
    logic [13:0] src_height_q = 14'd2048;

    src_t   expected_src [$];
    int     fail_cnt = 0;
    int     idle_cycles = 0;
    logic   pix_took = 1'b0;
    logic   cfg_took = 1'b0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    logic   long_hold = 1'b0;
    int     hold_cnt = 0;

    equirect_to_cube_face_address uut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .src_valid(src_valid), .src_stall(src_stall), .src(src),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // angle of point (b, a) in fractions of pi, vectoring CORDIC
    function automatic longint angle_of_point(longint a, longint b);
        longint px;
        longint py;
        longint acc;
        longint dx;
        longint dy;
        px = b;
        py = a;
        acc = 0;
        if (a == 0 && b == 0)
            return 0;
        if (px < 0)
        begin
            acc = (py >= 0) ? ANGLE_PI : -ANGLE_PI;
            px = -px;
            py = -py;
        end
        for (int i = 0; i < 18; i++)
        begin
            dx = px >>> i;
            dy = py >>> i;
            if (py >= 0)
            begin
                px = px + dy;
                py = py - dx;
                acc = acc + ATAN_LUT[i];
            end
            else
            begin
                px = px - dy;
                py = py + dx;
                acc = acc - ATAN_LUT[i];
            end
        end
        return acc;
    endfunction

    function automatic src_t source_pixel(pix_t p);
        longint f, w, hg, h, c, r, x, y, z, theta, phi, s;
        longint unsigned rad, sx, sy;
        int slot;
        src_t o;
        f = (face_size_q > 4096) ? 4096 : face_size_q;
        w = (src_width_q > 8192) ? 8192 : src_width_q;
        hg = (src_height_q > 8192) ? 8192 : src_height_q;
        slot = p.face_slot;
        c = p.column;
        r = p.row;
        h = f >> 1;
        o = '0;
        if (c >= f || r >= f)
        begin
            o.coord_invalid = 1'b1;
            return o;
        end
        if (slot >= 6)
            slot = slot - 2;
        case (slot)
            0: begin x = (f - r) - h; y = c - h; z = h; end
            1: begin x = h - (f - r); y = c - h; z = -h; end
            2: begin x = c - h; y = -h; z = r - h; end
            3: begin x = h - c; y = h; z = h - r; end
            4: begin x = h; y = c - h; z = r - h; end
            default: begin x = -h; y = c - h; z = h - r; end
        endcase
        theta = angle_of_point(x * 65536, z * 65536);
        rad = root_of(longint'(x * x + z * z) << 32);
        phi = angle_of_point(longint'(rad), y * 65536);
        s = ANGLE_PI + theta;
        if (s < 0) s = 0;
        if (s > 2 * ANGLE_PI) s = 2 * ANGLE_PI;
        if (phi < 0) phi = 0;
        if (phi > ANGLE_PI) phi = ANGLE_PI;
        sx = (longint'(s) * w) >> 19;
        sy = (longint'(phi) * hg) >> 18;
        sx = (w == 0) ? 0 : ((sx > w - 1) ? w - 1 : sx);
        sy = (hg == 0) ? 0 : ((sy > hg - 1) ? hg - 1 : sy);
        o.src_x = sx[12:0];
        o.src_y = sy[12:0];
        o.src_address = 26'(sx + sy * w);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_cnt++;
    endtask

    // predict on accept, check on output, watchdog on silence
    always @(posedge clk)
    begin
        src_t want;
        pix_took <= pix_valid && !pix_stall;
        cfg_took <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_FACE_SIZE:  face_size_q = cfg_data[12:0];
                    REG_SRC_WIDTH:  src_width_q = cfg_data;
                    REG_SRC_HEIGHT: src_height_q = cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                expected_src.push_back(source_pixel(pix));
            if (src_valid && !src_stall)
            begin
                if (expected_src.size() == 0)
                    report_mismatch("words pending on src channel", 1, 0);
                else
                begin
                    want = expected_src.pop_front();
                    if (src.src_x != want.src_x)
                        report_mismatch("src_x", src.src_x, want.src_x);
                    if (src.src_y != want.src_y)
                        report_mismatch("src_y", src.src_y, want.src_y);
                    if (src.src_address != want.src_address)
                        report_mismatch("src_address", src.src_address, want.src_address);
                    if (src.coord_invalid != want.coord_invalid)
                        report_mismatch("coord_invalid", src.coord_invalid,
                                        want.coord_invalid);
                end
            end
            if ((pix_valid && !pix_stall) || (src_valid && !src_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // output side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            src_stall <= 1'b0;
        else if (long_hold && hold_cnt < HOLD_LEN)
        begin
            src_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            if (!long_hold)
                hold_cnt <= 0;
            src_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    // with valid still high, so words can follow back to back
    task automatic send_pix(pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        do @(negedge clk); while (!pix_took);
    endtask

    task automatic wait_drain();
        pix_valid <= 1'b0;
        while (expected_src.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, int value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[DIM_W-1:0];
        do @(negedge clk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int f, int w, int hg);
        write_reg(REG_FACE_SIZE, f);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, hg);
    endtask

    function automatic pix_t make_pix(int slot, int col, int row);
        pix_t p;
        p.face_slot = slot[2:0];
        p.column = col[11:0];
        p.row = row[11:0];
        return p;
    endfunction

    function automatic pix_t random_pix();
        int f;
        f = (face_size_q > 4096) ? 4096 : face_size_q;
        if (f == 0 || $urandom_range(99) < 8)
            return make_pix($urandom_range(7), $urandom_range(4095), $urandom_range(4095));
        return make_pix($urandom_range(7), $urandom_range(f - 1), $urandom_range(f - 1));
    endfunction

    task automatic test_directed();
        int f;
        int h;
        f = 2048;
        h = 1024;
        for (int s = 0; s < 8; s++)
        begin
            send_pix(make_pix(s, 0, 0));
            send_pix(make_pix(s, f - 1, f - 1));
        end
        send_pix(make_pix(0, h, h));
        send_pix(make_pix(1, 5, h));         // seam, x = 0 and z < 0
        send_pix(make_pix(3, h, f - 1));     // seam on another slot
        send_pix(make_pix(2, f, 3));         // column out of range
        send_pix(make_pix(4, 3, 4095));      // row out of range
        send_pix(make_pix(7, 4095, 4095));
        wait_drain();
    endtask

    task automatic test_edge_geometry();
        set_geometry(4096, 8192, 8192);
        send_pix(make_pix(0, 4095, 4095));
        send_pix(make_pix(5, 4095, 0));
        send_pix(make_pix(2, 0, 2048));
        set_geometry(8191, 16383, 16383);    // oversized values get limited
        send_pix(make_pix(1, 4095, 1234));
        send_pix(make_pix(6, 100, 4095));
        set_geometry(1, 0, 0);               // face size 1, zero dims
        send_pix(make_pix(0, 0, 0));
        send_pix(make_pix(3, 0, 1));
        set_geometry(0, 1, 1);
        send_pix(make_pix(4, 0, 0));
        set_geometry(2, 1, 8192);
        for (int s = 0; s < 8; s++)
            send_pix(make_pix(s, s & 1, s >> 1 & 1));
        wait_drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n);
        int f;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        f = ($urandom_range(3) == 0) ? 4096 : 2 * $urandom_range(1, 2048);
        set_geometry(f, $urandom_range(1, 8192), $urandom_range(1, 8192));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 50)
            begin
                // unthrottled stretch
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            else if (i % 100 == 80)
            begin
                send_idle_pct = idle_pct;
                recv_stall_pct = stall_pct;
            end
            send_pix(random_pix());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_geometry(512, 2000, 1000);
        long_hold = 1'b1;
        for (int i = 0; i < 150; i++)
            send_pix(random_pix());
        long_hold = 1'b0;
        pix_valid <= 1'b0;
        // pause until every word is back, then resume
        while (expected_src.size() != 0)
            @(negedge clk);
        for (int i = 0; i < 30; i++)
            send_pix(random_pix());
        wait_drain();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_edge_geometry();
        test_random_phase(0, 0, 350);
        test_random_phase(69, 0, 350);
        test_random_phase(0, 69, 350);
        test_random_phase(22, 22, 350);
        test_backpressure();
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/core/e2c_pkg.sv
rtl/core/e2c_dir.sv
rtl/core/e2c_sqrt.sv
rtl/core/e2c_cordic.sv
rtl/core/e2c_scale.sv
rtl/core/equirect_to_cube_face_address.sv
test/equirect_to_cube_face_address_test.sv
